// ===== rtl/wbfb_pkg.sv =====
// shared constants, types and frame byte functions for the beacon frame builder
`default_nettype none
package wbfb_pkg;

  localparam int MAX_SSID_BYTES     = 32;
  localparam int OUT_BYTES_PER_WORD = 4;
  localparam int WORD_W             = 8 * OUT_BYTES_PER_WORD;
  localparam int POS_W              = 7;
  localparam int SSID_LEN_W         = 6;
  localparam int SSID_W             = 8 * MAX_SSID_BYTES;
  localparam int CNT_W              = 3;

  // byte offsets inside the frame
  localparam logic [POS_W-1:0] FIXED_BYTES   = 7'd36;
  localparam logic [POS_W-1:0] SSID_HDR_POS  = 7'd36;
  localparam logic [POS_W-1:0] SSID_LEN_POS  = 7'd37;
  localparam logic [POS_W-1:0] SSID_DATA_POS = 7'd38;
  localparam logic [POS_W-1:0] OPEN_TAIL     = 7'd19;
  localparam logic [POS_W-1:0] RSN_TAIL      = 7'd41;
  localparam logic [POS_W-1:0] OPEN_FIXED    = 7'd57;
  localparam logic [POS_W-1:0] RSN_BYTES     = 7'd22;

  localparam logic [7:0] FC_BEACON   = 8'h80;
  localparam logic [7:0] BCAST       = 8'hFF;
  localparam logic [7:0] INTERVAL_TU = 8'h64;
  localparam logic [7:0] CAP_ESS     = 8'h01;
  localparam logic [7:0] CAP_PRIV    = 8'h10;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

  // rates, ds parameter, extended rates and rsn elements, indexed after the ssid
  function automatic logic [7:0] tail_byte(input logic [5:0] q, input logic [7:0] ch);
    logic [7:0] b;
    case (q)
      6'd0:  b = 8'h01;
      6'd1:  b = 8'h08;
      6'd2:  b = 8'h82;
      6'd3:  b = 8'h84;
      6'd4:  b = 8'h8B;
      6'd5:  b = 8'h96;
      6'd6:  b = 8'h0C;
      6'd7:  b = 8'h12;
      6'd8:  b = 8'h18;
      6'd9:  b = 8'h24;
      6'd10: b = 8'h03;
      6'd11: b = 8'h01;
      6'd12: b = ch;
      6'd13: b = 8'h32;
      6'd14: b = 8'h04;
      6'd15: b = 8'h30;
      6'd16: b = 8'h48;
      6'd17: b = 8'h60;
      6'd18: b = 8'h6C;
      6'd19: b = 8'h30;
      6'd20: b = 8'h14;
      6'd21: b = 8'h01;
      6'd24: b = 8'h0F;
      6'd25: b = 8'hAC;
      6'd26: b = 8'h04;
      6'd27: b = 8'h01;
      6'd30: b = 8'h0F;
      6'd31: b = 8'hAC;
      6'd32: b = 8'h04;
      6'd33: b = 8'h01;
      6'd36: b = 8'h0F;
      6'd37: b = 8'hAC;
      6'd38: b = 8'h02;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // one frame byte at position p; zero past the frame end
  function automatic logic [7:0] frame_byte(
    input logic [POS_W-1:0]      p,
    input logic [SSID_LEN_W-1:0] l,
    input logic                  priv,
    input logic [47:0]           bssid,
    input logic [7:0]            ch,
    input logic [SSID_W-1:0]     ssid
  );
    logic [POS_W-1:0] ssid_end;
    logic [POS_W-1:0] q_full;
    logic [POS_W-1:0] tail_len;
    logic [POS_W-1:0] a2_off;
    logic [POS_W-1:0] a3_off;
    logic [POS_W-1:0] s_off;
    logic [7:0]       b;
    ssid_end = SSID_DATA_POS + {1'b0, l};
    q_full   = p - ssid_end;
    tail_len = priv ? RSN_TAIL : OPEN_TAIL;
    a2_off   = p - 7'd10;
    a3_off   = p - 7'd16;
    s_off    = p - SSID_DATA_POS;
    b        = 8'h00;
    if (p < FIXED_BYTES) begin
      if (p == 7'd0) begin
        b = FC_BEACON;
      end else if (p >= 7'd4 && p < 7'd10) begin
        b = BCAST;
      end else if (p >= 7'd10 && p < 7'd16) begin
        b = bssid[a2_off[2:0]*8 +: 8];
      end else if (p >= 7'd16 && p < 7'd22) begin
        b = bssid[a3_off[2:0]*8 +: 8];
      end else if (p == 7'd32) begin
        b = INTERVAL_TU;
      end else if (p == 7'd34) begin
        b = priv ? (CAP_ESS | CAP_PRIV) : CAP_ESS;
      end
    end else if (p == SSID_HDR_POS) begin
      b = 8'h00;
    end else if (p == SSID_LEN_POS) begin
      b = {2'b00, l};
    end else if (p < ssid_end) begin
      b = ssid[s_off[4:0]*8 +: 8];
    end else if (q_full < tail_len) begin
      b = tail_byte(q_full[5:0], ch);
    end
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/wbfb_ctrl.sv =====
// controller state machine: request accept and word emit sequencing
`default_nettype none
module wbfb_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output wbfb_pkg::cmd_t       cmd,
  input  wire wbfb_pkg::status_t sts
);

  wbfb_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             can_emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wbfb_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output register is free when empty or its beat leaves this cycle
  assign can_emit = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = 1'b1;
    case (state_r)
      wbfb_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = wbfb_pkg::ST_SEND;
        end
      end
      wbfb_pkg::ST_SEND: begin
        if (can_emit) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          if (sts.last) begin
            state_nxt = wbfb_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = wbfb_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  a_load_to_send: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == wbfb_pkg::ST_SEND)
    else $error("load did not start a frame");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall))
    else $error("emit over a held beat");

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == wbfb_pkg::ST_SEND |-> in_stall && !cmd.load)
    else $error("request taken mid frame");

  a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && sts.last |=> state_r == wbfb_pkg::ST_IDLE && out_valid_r)
    else $error("last word did not end the frame");

endmodule
`default_nettype wire

// ===== rtl/wbfb_dp.sv =====
// datapath: held request fields, byte position and output word register
`default_nettype none
module wbfb_dp (
  input  wire logic                                    clk,
  input  wire wbfb_pkg::cmd_t                          cmd,
  output wbfb_pkg::status_t                            sts,
  input  wire logic [47:0]                             in_bssid,
  input  wire logic [7:0]                              in_channel,
  input  wire logic                                    in_encrypted,
  input  wire logic [wbfb_pkg::SSID_LEN_W-1:0]         in_ssid_len,
  input  wire logic [wbfb_pkg::SSID_W-1:0]             in_ssid,
  output logic [wbfb_pkg::WORD_W-1:0]                  out_frame_word,
  output logic [wbfb_pkg::CNT_W-1:0]                   out_bytes_valid,
  output logic                                         out_last_word
);

  localparam logic [wbfb_pkg::POS_W-1:0] STEP = wbfb_pkg::POS_W'(wbfb_pkg::OUT_BYTES_PER_WORD);
  localparam logic [wbfb_pkg::SSID_LEN_W-1:0] MAX_LEN =
    wbfb_pkg::SSID_LEN_W'(wbfb_pkg::MAX_SSID_BYTES);

  logic [47:0]                         bssid_r;
  logic [7:0]                          channel_r;
  logic                                priv_r;
  logic [wbfb_pkg::SSID_LEN_W-1:0]     len_r;
  logic [wbfb_pkg::SSID_W-1:0]         ssid_r;
  logic [wbfb_pkg::POS_W-1:0]          frame_len_r;
  logic [wbfb_pkg::POS_W-1:0]          pos_r;
  logic [wbfb_pkg::WORD_W-1:0]         word_r;
  logic [wbfb_pkg::CNT_W-1:0]          cnt_r;
  logic                                last_r;

  logic [wbfb_pkg::SSID_LEN_W-1:0]     len_sat;
  logic [wbfb_pkg::POS_W-1:0]          frame_len_nxt;
  logic [wbfb_pkg::POS_W-1:0]          remain;
  logic [wbfb_pkg::WORD_W-1:0]         word_nxt;
  logic [wbfb_pkg::CNT_W-1:0]          cnt_nxt;

  assign len_sat       = (in_ssid_len > MAX_LEN) ? MAX_LEN : in_ssid_len;
  assign frame_len_nxt = wbfb_pkg::OPEN_FIXED + {1'b0, len_sat} +
                         (in_encrypted ? wbfb_pkg::RSN_BYTES : '0);

  assign remain   = frame_len_r - pos_r;
  assign sts.last = remain <= STEP;
  assign cnt_nxt  = sts.last ? remain[wbfb_pkg::CNT_W-1:0] :
                    wbfb_pkg::CNT_W'(wbfb_pkg::OUT_BYTES_PER_WORD);

  // one byte lane per output byte
  always_comb begin
    word_nxt = '0;
    for (int i = 0; i < wbfb_pkg::OUT_BYTES_PER_WORD; i++) begin
      word_nxt[i*8 +: 8] = wbfb_pkg::frame_byte(pos_r + wbfb_pkg::POS_W'(i), len_r, priv_r,
                                                bssid_r, channel_r, ssid_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bssid_r     <= in_bssid;
      channel_r   <= in_channel;
      priv_r      <= in_encrypted;
      len_r       <= len_sat;
      ssid_r      <= in_ssid;
      frame_len_r <= frame_len_nxt;
      pos_r       <= '0;
    end else if (cmd.emit) begin
      pos_r <= pos_r + STEP;
    end
    if (cmd.emit) begin
      word_r <= word_nxt;
      cnt_r  <= cnt_nxt;
      last_r <= sts.last;
    end
  end

  assign out_frame_word  = word_r;
  assign out_bytes_valid = cnt_r;
  assign out_last_word   = last_r;

endmodule
`default_nettype wire

// ===== rtl/wifi_beacon_frame_builder.sv =====
// beacon frame builder top level: controller plus datapath
//
//   channel  dir  payload                                          handshake
//   in_      in   bssid, channel, encrypted, ssid_len, ssid_word_* in_valid / in_stall
//   out_     out  frame_word, bytes_valid, last_word               out_valid / out_stall
//
// a frame of 57 + ssid bytes (+22 rsn) leaves as 15 to 28 words, one per unstalled cycle
// the word rate is set by the byte position counter in the datapath, four byte lanes wide
// a new request is taken the cycle after the last word enters the output register
// reset clears the state machine and the output valid; held request fields need none
// out_stall holds the output register and pauses the position counter
`default_nettype none
module wifi_beacon_frame_builder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [47:0] in_bssid,
  input  wire logic [7:0]  in_channel,
  input  wire logic        in_encrypted,
  input  wire logic [5:0]  in_ssid_len,
  input  wire logic [63:0] in_ssid_word_0,
  input  wire logic [63:0] in_ssid_word_1,
  input  wire logic [63:0] in_ssid_word_2,
  input  wire logic [63:0] in_ssid_word_3,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_frame_word,
  output logic [2:0]       out_bytes_valid,
  output logic             out_last_word
);

  wbfb_pkg::cmd_t    cmd;
  wbfb_pkg::status_t sts;

  wbfb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  wbfb_dp u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .sts             (sts),
    .in_bssid        (in_bssid),
    .in_channel      (in_channel),
    .in_encrypted    (in_encrypted),
    .in_ssid_len     (in_ssid_len),
    .in_ssid         ({in_ssid_word_3, in_ssid_word_2, in_ssid_word_1, in_ssid_word_0}),
    .out_frame_word  (out_frame_word),
    .out_bytes_valid (out_bytes_valid),
    .out_last_word   (out_last_word)
  );

endmodule
`default_nettype wire

// ===== sim/tb_wifi_beacon_frame_builder.sv =====
// self-checking testbench for the beacon frame builder: directed, hold-off and random frames
`default_nettype none
module tb_wifi_beacon_frame_builder;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int IDLE_PCT     = 19;
  localparam int RANDOM_ITEMS = 480;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;

  // element bytes in frame order, first byte in the top bits
  localparam logic [8*10-1:0] RATES_IE     = 80'h01_08_82_84_8B_96_0C_12_18_24;
  localparam logic [8*6-1:0]  EXT_RATES_IE = 48'h32_04_30_48_60_6C;
  localparam logic [8*22-1:0] RSN_IE       =
    176'h30_14_01_00_00_0F_AC_04_01_00_00_0F_AC_04_01_00_00_0F_AC_02_00_00;
  localparam logic [7:0] SSID_IE_ID = 8'h00;
  localparam logic [7:0] DS_IE_ID   = 8'h03;
  localparam logic [7:0] DS_IE_LEN  = 8'h01;

  typedef struct packed {
    logic [47:0] bssid;
    logic [7:0]  channel;
    logic        encrypted;
    logic [5:0]  ssid_len;
    logic [63:0] ssid_w0;
    logic [63:0] ssid_w1;
    logic [63:0] ssid_w2;
    logic [63:0] ssid_w3;
  } beacon_req_t;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  count;
    logic        last;
  } frame_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [47:0] in_bssid;
  logic [7:0]  in_channel;
  logic        in_encrypted;
  logic [5:0]  in_ssid_len;
  logic [63:0] in_ssid_word_0;
  logic [63:0] in_ssid_word_1;
  logic [63:0] in_ssid_word_2;
  logic [63:0] in_ssid_word_3;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_frame_word;
  logic [2:0]  out_bytes_valid;
  logic        out_last_word;

  frame_beat_t beats_due[$];
  int          mismatches;
  int          cycles;
  bit          quiet;
  int          hold_left;

  wifi_beacon_frame_builder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_bssid       (in_bssid),
    .in_channel     (in_channel),
    .in_encrypted   (in_encrypted),
    .in_ssid_len    (in_ssid_len),
    .in_ssid_word_0 (in_ssid_word_0),
    .in_ssid_word_1 (in_ssid_word_1),
    .in_ssid_word_2 (in_ssid_word_2),
    .in_ssid_word_3 (in_ssid_word_3),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_word (out_frame_word),
    .out_bytes_valid(out_bytes_valid),
    .out_last_word  (out_last_word)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // builds the whole beacon for one request and queues its words
  function automatic void predict_beacon(input beacon_req_t r);
    logic [7:0]     fb[$];
    logic [255:0]   ssid_flat;
    frame_beat_t    w;
    int             n_ssid;
    int             pos;
    int             cnt;
    n_ssid = (r.ssid_len > wbfb_pkg::MAX_SSID_BYTES) ? wbfb_pkg::MAX_SSID_BYTES
                                                      : int'(r.ssid_len);
    ssid_flat = {r.ssid_w3, r.ssid_w2, r.ssid_w1, r.ssid_w0};
    fb = {wbfb_pkg::FC_BEACON, 8'h00, 8'h00, 8'h00};
    repeat (6) fb = {fb, wbfb_pkg::BCAST};
    for (int i = 0; i < 6; i++) fb = {fb, r.bssid[8*i +: 8]};
    for (int i = 0; i < 6; i++) fb = {fb, r.bssid[8*i +: 8]};
    // sequence control, then the zero timestamp
    repeat (10) fb = {fb, 8'h00};
    fb = {fb, wbfb_pkg::INTERVAL_TU};
    fb = {fb, 8'h00};
    fb = {fb, r.encrypted ? (wbfb_pkg::CAP_ESS | wbfb_pkg::CAP_PRIV) : wbfb_pkg::CAP_ESS};
    fb = {fb, 8'h00};
    fb = {fb, SSID_IE_ID};
    fb = {fb, 8'(n_ssid)};
    for (int i = 0; i < n_ssid; i++) fb = {fb, ssid_flat[8*i +: 8]};
    for (int i = 9; i >= 0; i--) fb = {fb, RATES_IE[8*i +: 8]};
    fb = {fb, DS_IE_ID};
    fb = {fb, DS_IE_LEN};
    fb = {fb, r.channel};
    for (int i = 5; i >= 0; i--) fb = {fb, EXT_RATES_IE[8*i +: 8]};
    if (r.encrypted) begin
      for (int i = 21; i >= 0; i--) fb = {fb, RSN_IE[8*i +: 8]};
    end
    for (pos = 0; pos < fb.size(); pos += wbfb_pkg::OUT_BYTES_PER_WORD) begin
      cnt = fb.size() - pos;
      if (cnt > wbfb_pkg::OUT_BYTES_PER_WORD) cnt = wbfb_pkg::OUT_BYTES_PER_WORD;
      w.data = '0;
      for (int k = 0; k < cnt; k++) w.data[8*k +: 8] = fb[pos+k];
      w.count = 3'(cnt);
      w.last  = (pos + cnt >= fb.size());
      beats_due = {beats_due, w};
    end
  endfunction

  always @(posedge clk) begin
    frame_beat_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (beats_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: word %h count %0d last %0b",
                   out_frame_word, out_bytes_valid, out_last_word);
      end else begin
        e = beats_due.pop_front();
        if (out_frame_word !== e.data || out_bytes_valid !== e.count ||
            out_last_word !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat mismatch: exp word %h count %0d last %0b, got %h %0d %0b",
                     e.data, e.count, e.last, out_frame_word, out_bytes_valid,
                     out_last_word);
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        while (hold_left > 0) begin
          @(negedge clk);
          hold_left--;
        end
      end else begin
        out_stall = !quiet && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  task automatic send_request(input beacon_req_t r);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_bssid       = r.bssid;
    in_channel     = r.channel;
    in_encrypted   = r.encrypted;
    in_ssid_len    = r.ssid_len;
    in_ssid_word_0 = r.ssid_w0;
    in_ssid_word_1 = r.ssid_w1;
    in_ssid_word_2 = r.ssid_w2;
    in_ssid_word_3 = r.ssid_w3;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beacon(r);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (beats_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic beacon_req_t random_request();
    beacon_req_t r;
    r.bssid     = {16'($urandom()), 32'($urandom())};
    r.channel   = 8'($urandom());
    r.encrypted = 1'($urandom());
    // mostly lengths that fit, a share that saturate
    if ($urandom_range(99) < 75) r.ssid_len = 6'($urandom_range(wbfb_pkg::MAX_SSID_BYTES));
    else r.ssid_len = 6'($urandom_range(63, wbfb_pkg::MAX_SSID_BYTES + 1));
    r.ssid_w0 = rand64();
    r.ssid_w1 = rand64();
    r.ssid_w2 = rand64();
    r.ssid_w3 = rand64();
    return r;
  endfunction

  task automatic test_field_extremes();
    beacon_req_t r;
    r = '0;
    send_request(r);
    r = '1;
    send_request(r);
    r = '1;
    r.encrypted = 1'b0;
    r.ssid_len  = 6'(wbfb_pkg::MAX_SSID_BYTES);
    send_request(r);
    r = random_request();
    r.ssid_len  = 6'(wbfb_pkg::MAX_SSID_BYTES + 1);
    r.encrypted = 1'b1;
    send_request(r);
    // zero bytes inside the ssid still count
    r = random_request();
    r.ssid_len = 6'd31;
    r.ssid_w0  = '0;
    r.ssid_w1  = 64'h00FF_0000_FF00_0000;
    r.ssid_w2  = '0;
    r.ssid_w3  = '0;
    send_request(r);
    r = random_request();
    r.channel = 8'h00;
    send_request(r);
    r = random_request();
    r.channel = 8'hFF;
    send_request(r);
    stop_sending();
  endtask

  // short lengths walk the last word through every byte count, open and private
  task automatic test_tail_alignment();
    beacon_req_t r;
    for (int p = 0; p < 2; p++) begin
      for (int n = 1; n <= 4; n++) begin
        r = random_request();
        r.encrypted = 1'(p);
        r.ssid_len  = 6'(n);
        send_request(r);
      end
    end
    stop_sending();
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    repeat (30) send_request(random_request());
    stop_sending();
    wait_drained();
    quiet = 1'b0;
  endtask

  task automatic test_output_holdoff();
    quiet     = 1'b1;
    hold_left = HOLD_CYCLES;
    repeat (6) send_request(random_request());
    stop_sending();
    wait_drained();
    quiet = 1'b0;
  endtask

  task automatic test_random_frames();
    repeat (RANDOM_ITEMS) send_request(random_request());
    stop_sending();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_bssid       = '0;
    in_channel     = '0;
    in_encrypted   = 1'b0;
    in_ssid_len    = '0;
    in_ssid_word_0 = '0;
    in_ssid_word_1 = '0;
    in_ssid_word_2 = '0;
    in_ssid_word_3 = '0;
    mismatches     = 0;
    cycles         = 0;
    quiet          = 1'b0;
    hold_left      = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_field_extremes();
    test_tail_alignment();
    test_back_to_back();
    test_output_holdoff();
    test_random_frames();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
